// ----- sv/mpo_pkg.sv -----
// Package with phase codes, error codes and field constants for the MPO index parser.
`default_nettype none
package mpo_pkg;
   localparam logic [3:0] PH_SOI     = 4'd0;
   localparam logic [3:0] PH_MARKER  = 4'd1;
   localparam logic [3:0] PH_SKIPSEG = 4'd2;
   localparam logic [3:0] PH_MPF     = 4'd3;
   localparam logic [3:0] PH_MPHDR   = 4'd4;
   localparam logic [3:0] PH_SKIPIFD = 4'd5;
   localparam logic [3:0] PH_COUNT   = 4'd6;
   localparam logic [3:0] PH_TAG     = 4'd7;
   localparam logic [3:0] PH_NEXTIFD = 4'd8;
   localparam logic [3:0] PH_ENTRY   = 4'd9;
   localparam logic [3:0] PH_DONE    = 4'd10;
   localparam logic [3:0] PH_HALT    = 4'd11;

   localparam logic [4:0] ERR_NONE       = 5'd0;
   localparam logic [4:0] ERR_NO_SOI     = 5'd1;
   localparam logic [4:0] ERR_MARKER     = 5'd2;
   localparam logic [4:0] ERR_SHORT_SEG  = 5'd3;
   localparam logic [4:0] ERR_NOT_MPF    = 5'd4;
   localparam logic [4:0] ERR_ENDIAN     = 5'd5;
   localparam logic [4:0] ERR_IFD_OFS    = 5'd6;
   localparam logic [4:0] ERR_B000_TYPE  = 5'd7;
   localparam logic [4:0] ERR_B000_CNT   = 5'd8;
   localparam logic [4:0] ERR_B000_VER   = 5'd9;
   localparam logic [4:0] ERR_B001_TYPE  = 5'd10;
   localparam logic [4:0] ERR_B001_CNT   = 5'd11;
   localparam logic [4:0] ERR_B002_TYPE  = 5'd12;
   localparam logic [4:0] ERR_B002_CNT   = 5'd13;
   localparam logic [4:0] ERR_B003_TYPE  = 5'd14;
   localparam logic [4:0] ERR_B003_CNT   = 5'd15;
   localparam logic [4:0] ERR_B004_TYPE  = 5'd16;
   localparam logic [4:0] ERR_B004_CNT   = 5'd17;
   localparam logic [4:0] ERR_BAD_TAG    = 5'd18;
   localparam logic [4:0] ERR_NO_IMAGES  = 5'd19;

   localparam logic [15:0] TAG_VERSION = 16'hB000;
   localparam logic [15:0] TAG_NUM_IMG = 16'hB001;
   localparam logic [15:0] TAG_ENTRY   = 16'hB002;
   localparam logic [15:0] TAG_UID     = 16'hB003;
   localparam logic [15:0] TAG_FRAMES  = 16'hB004;
   localparam logic [15:0] TYPE_UNDEF  = 16'd7;
   localparam logic [15:0] TYPE_LONG   = 16'd4;

   localparam logic [7:0] MK_PREFIX = 8'hFF;
   localparam logic [7:0] MK_SOI    = 8'hD8;
   localparam logic [7:0] MK_APP2   = 8'hE2;

   typedef struct packed {
      logic        is_error;
      logic [4:0]  error_code;
      logic [31:0] image_index;
      logic [32:0] image_location;
      logic        last;
   } result_type;
endpackage
`default_nettype wire

// ----- sv/mpo_index_parser_unit.sv -----
// Top level of the MPO index parser: byte parser with a registered result stage.
`default_nettype none
// The parser takes one file byte per item and accepts a new byte every cycle as long
// as the result register is free or being emptied in the same cycle. Each accepted
// byte updates the parse state in the same clock; when a byte completes a field that
// yields an image location or an error, that result is written to the output register
// and appears on the rsp_ port in the next cycle. The rate is one item per cycle, set by
// the single result register: req_ready drops only while a result waits and rsp_ready
// is low. req_file_start high restarts the parser with that byte as the first of a new
// file. After an error, or after the last image location, bytes are consumed without
// results until the next file start. Positions wrap at POSITION_BITS bits; the image
// location is the MP header start plus the entry offset, kept to 33 bits.
module mpo_index_parser_unit #(
   parameter int POSITION_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_file_start,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_is_error,
   output logic [4:0]       rsp_error_code,
   output logic [31:0]      rsp_image_index,
   output logic [32:0]      rsp_image_location,
   output logic             rsp_last
);
   import mpo_pkg::*;

   logic                     res_valid;
   result_type               res_data;
   result_type               out_data;
   logic                     accept;

   assign accept = req_valid && req_ready;

   mpo_parse_core #(.POSITION_BITS(POSITION_BITS)) u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .file_start (req_file_start),
      .res_valid  (res_valid),
      .res_data   (res_data)
   );

   mpo_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res_data),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .out_ready (rsp_ready)
   );

   assign rsp_is_error       = out_data.is_error;
   assign rsp_error_code     = out_data.error_code;
   assign rsp_image_index    = out_data.image_index;
   assign rsp_image_location = out_data.image_location;
   assign rsp_last           = out_data.last;
endmodule
`default_nettype wire

// ----- sv/mpo_out_reg.sv -----
// Output register stage that holds one result item and takes a new one when free or being emptied.
`default_nettype none
module mpo_out_reg (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire mpo_pkg::result_type in_data,
   output logic                    in_ready,
   output logic                    out_valid,
   output mpo_pkg::result_type     out_data,
   input  wire logic               out_ready
);
   import mpo_pkg::*;
   logic       valid_ff;
   result_type data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= in_data;
      end
   end
endmodule
`default_nettype wire

// ----- sv/mpo_parse_core.sv -----
// Byte-level parse state machine with the field buffer and all field checks.
`default_nettype none
module mpo_parse_core #(
   parameter int POSITION_BITS = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         accept,
   input  wire logic [7:0]   data_byte,
   input  wire logic         file_start,
   output logic              res_valid,
   output mpo_pkg::result_type res_data
);
   import mpo_pkg::*;

   logic [3:0]               phase_ff, phase_in;
   logic [3:0]               bif_ff, bif_in;
   logic [7:0]               fb_ff [16];
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] hdr_ff, hdr_in;
   logic [31:0]              skip_ff, skip_in;
   logic                     be_ff, be_in;
   logic [15:0]              tags_ff, tags_in;
   logic [31:0]              count_ff, count_in;
   logic [31:0]              entry_ff, entry_in;

   // Effective state after an optional restart.
   logic [3:0]               ph;
   logic [3:0]               bif;
   logic [POSITION_BITS-1:0] pos;
   logic                     be;
   logic [15:0]              tags;
   logic [31:0]              imgs;
   logic [31:0]              ent;
   logic [31:0]              skp;
   logic [POSITION_BITS-1:0] hdr;
   logic [7:0]               f [16];
   logic [3:0]               flen;
   logic                     done_field;
   logic [15:0]              tag, typ, v16;
   logic [31:0]              cnt, v32, ofs;
   logic [15:0]              tags_dec;
   logic                     err;
   logic [4:0]               code;
   logic [32:0]              hdr33;

   function automatic logic [15:0] rd16(input logic [7:0] a, input logic [7:0] b,
                                        input logic big);
      rd16 = big ? {a, b} : {b, a};
   endfunction

   always_comb begin
      ph   = file_start ? PH_SOI : phase_ff;
      bif  = file_start ? 4'd0 : bif_ff;
      pos  = file_start ? '0 : pos_ff;
      be   = file_start ? 1'b0 : be_ff;
      tags = file_start ? 16'd0 : tags_ff;
      imgs = file_start ? 32'd0 : count_ff;
      ent  = file_start ? 32'd0 : entry_ff;
      skp  = file_start ? 32'd0 : skip_ff;
      hdr  = file_start ? '0 : hdr_ff;
      for (int i = 0; i < 16; i++) begin
         f[i] = (bif == 4'(i)) ? data_byte : fb_ff[i];
      end
      unique case (ph)
         PH_SOI, PH_COUNT: flen = 4'd1;
         PH_MPHDR:         flen = 4'd7;
         PH_TAG:           flen = 4'd11;
         PH_ENTRY:         flen = 4'd15;
         default:          flen = 4'd3;
      endcase
      done_field = (bif == flen);

      tag = rd16(f[0], f[1], be);
      typ = rd16(f[2], f[3], be);
      cnt = be ? {f[4], f[5], f[6], f[7]} : {f[7], f[6], f[5], f[4]};
      v32 = be ? {f[8], f[9], f[10], f[11]} : {f[11], f[10], f[9], f[8]};
      v16 = {f[2], f[3]};
      ofs = (f[0] == 8'h4D) ? {f[4], f[5], f[6], f[7]} : {f[7], f[6], f[5], f[4]};
      tags_dec = tags - 16'd1;
      hdr33 = 33'(hdr);

      phase_in = ph;
      bif_in   = bif;
      pos_in   = pos + 1'b1;
      hdr_in   = hdr;
      skip_in  = skp;
      be_in    = be;
      tags_in  = tags;
      count_in = imgs;
      entry_in = ent;
      err      = 1'b0;
      code     = ERR_NONE;
      res_valid = 1'b0;
      res_data  = '0;

      if (ph == PH_HALT || ph == PH_DONE) begin
         // Bytes are dropped until a new file starts.
      end else if (ph == PH_SKIPSEG || ph == PH_SKIPIFD) begin
         skip_in = skp - 32'd1;
         if (skip_in == 32'd0) begin
            phase_in = (ph == PH_SKIPSEG) ? PH_MARKER : PH_COUNT;
         end
      end else if (!done_field) begin
         bif_in = bif + 4'd1;
      end else begin
         bif_in = 4'd0;
         unique case (ph)
            PH_SOI: begin
               if (f[0] != MK_PREFIX || f[1] != MK_SOI) begin
                  err = 1'b1; code = ERR_NO_SOI;
               end else begin
                  phase_in = PH_MARKER;
               end
            end
            PH_MARKER: begin
               if (f[0] != MK_PREFIX) begin
                  err = 1'b1; code = ERR_MARKER;
               end else if (f[1] == MK_APP2) begin
                  phase_in = PH_MPF;
               end else if (v16 < 16'd2) begin
                  err = 1'b1; code = ERR_SHORT_SEG;
               end else begin
                  skip_in  = 32'(v16 - 16'd2);
                  phase_in = (v16 != 16'd2) ? PH_SKIPSEG : PH_MARKER;
               end
            end
            PH_MPF: begin
               if (f[0] != 8'h4D || f[1] != 8'h50 || f[2] != 8'h46 || f[3] != 8'h00) begin
                  err = 1'b1; code = ERR_NOT_MPF;
               end else begin
                  hdr_in   = pos + 1'b1;
                  phase_in = PH_MPHDR;
               end
            end
            PH_MPHDR: begin
               if (f[0] == 8'h49 && f[1] == 8'h49 && f[2] == 8'h2A && f[3] == 8'h00) begin
                  be_in = 1'b0;
               end else if (f[0] == 8'h4D && f[1] == 8'h4D && f[2] == 8'h00
                            && f[3] == 8'h2A) begin
                  be_in = 1'b1;
               end else begin
                  err = 1'b1; code = ERR_ENDIAN;
               end
               if (!err) begin
                  if (ofs < 32'd8) begin
                     err = 1'b1; code = ERR_IFD_OFS;
                  end else begin
                     skip_in  = ofs - 32'd8;
                     phase_in = (ofs != 32'd8) ? PH_SKIPIFD : PH_COUNT;
                  end
               end
            end
            PH_COUNT: begin
               tags_in = tag;
               if (tag == 16'd0) begin
                  if (imgs == 32'd0) begin
                     err = 1'b1; code = ERR_NO_IMAGES;
                  end else begin
                     phase_in = PH_NEXTIFD;
                  end
               end else begin
                  phase_in = PH_TAG;
               end
            end
            PH_TAG: begin
               case (tag)
                  TAG_VERSION: begin
                     if (typ != TYPE_UNDEF) begin
                        err = 1'b1; code = ERR_B000_TYPE;
                     end else if (cnt != 32'd4) begin
                        err = 1'b1; code = ERR_B000_CNT;
                     end else if (f[8] != 8'h30 || f[9] != 8'h31 || f[10] != 8'h30
                                  || f[11] != 8'h30) begin
                        err = 1'b1; code = ERR_B000_VER;
                     end
                  end
                  TAG_NUM_IMG: begin
                     if (typ != TYPE_LONG) begin
                        err = 1'b1; code = ERR_B001_TYPE;
                     end else if (cnt != 32'd1) begin
                        err = 1'b1; code = ERR_B001_CNT;
                     end else begin
                        count_in = v32;
                     end
                  end
                  TAG_ENTRY: begin
                     if (typ != TYPE_UNDEF) begin
                        err = 1'b1; code = ERR_B002_TYPE;
                     end else if ({4'd0, cnt} != {imgs, 4'd0}) begin
                        err = 1'b1; code = ERR_B002_CNT;
                     end
                  end
                  TAG_UID: begin
                     if (typ != TYPE_UNDEF) begin
                        err = 1'b1; code = ERR_B003_TYPE;
                     end else if ({6'd0, cnt} != ({imgs, 5'd0} + {5'd0, imgs})) begin
                        err = 1'b1; code = ERR_B003_CNT;
                     end
                  end
                  TAG_FRAMES: begin
                     if (typ != TYPE_LONG) begin
                        err = 1'b1; code = ERR_B004_TYPE;
                     end else if (cnt != 32'd1) begin
                        err = 1'b1; code = ERR_B004_CNT;
                     end
                  end
                  default: begin
                     err = 1'b1; code = ERR_BAD_TAG;
                  end
               endcase
               if (!err) begin
                  tags_in = tags_dec;
                  if (tags_dec == 16'd0) begin
                     if (count_in == 32'd0) begin
                        err = 1'b1; code = ERR_NO_IMAGES;
                     end else begin
                        phase_in = PH_NEXTIFD;
                     end
                  end
               end
            end
            PH_NEXTIFD: begin
               entry_in = 32'd0;
               phase_in = PH_ENTRY;
            end
            PH_ENTRY: begin
               res_valid = 1'b1;
               res_data.image_index    = ent;
               res_data.image_location = hdr33 + {1'b0, v32};
               res_data.last           = (ent == imgs - 32'd1);
               entry_in = ent + 32'd1;
               if (res_data.last) begin
                  phase_in = PH_DONE;
               end
            end
            default: begin
            end
         endcase
         if (err) begin
            phase_in  = PH_HALT;
            res_valid = 1'b1;
            res_data  = '0;
            res_data.is_error   = 1'b1;
            res_data.error_code = code;
            res_data.last       = 1'b1;
         end
      end
      res_valid = res_valid && accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SOI;
         bif_ff   <= 4'd0;
         pos_ff   <= '0;
         hdr_ff   <= '0;
         skip_ff  <= 32'd0;
         be_ff    <= 1'b0;
         tags_ff  <= 16'd0;
         count_ff <= 32'd0;
         entry_ff <= 32'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         bif_ff   <= bif_in;
         pos_ff   <= pos_in;
         hdr_ff   <= hdr_in;
         skip_ff  <= skip_in;
         be_ff    <= be_in;
         tags_ff  <= tags_in;
         count_ff <= count_in;
         entry_ff <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fb_ff[bif] <= data_byte;
      end
   end
endmodule
`default_nettype wire

// ----- sv/mpo_checker.sv -----
// Port-level checker for the MPO index parser, bound to the top level.
`default_nettype none
module mpo_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_is_error,
   input wire logic [4:0]  rsp_error_code,
   input wire logic [31:0] rsp_image_index,
   input wire logic        rsp_last
);
   import mpo_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_error_code))
      else $error("result changed while stalled");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_error |-> rsp_last && rsp_error_code != ERR_NONE
         && rsp_image_index == 32'd0)
      else $error("error result malformed");

   a_loc_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_error |-> rsp_error_code == ERR_NONE)
      else $error("location result carries an error code");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input stalled with a free result register");
endmodule

bind mpo_index_parser_unit mpo_checker u_mpo_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_is_error   (rsp_is_error),
   .rsp_error_code (rsp_error_code),
   .rsp_image_index(rsp_image_index),
   .rsp_last       (rsp_last)
);
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the MPO index parser: byte streams in, image locations out.
`default_nettype none
module tb_top;
   import mpo_pkg::*;

   // One expected or observed result item.
   typedef struct packed {
      logic        is_error;
      logic [4:0]  error_code;
      logic [31:0] image_index;
      logic [32:0] image_location;
      logic        last;
   } loc_item_type;

   // Scoreboard: it predicts the parser state per accepted byte and checks each result.
   class mpo_scoreboard;
      logic [3:0]  phase;
      int unsigned fill;
      logic [7:0]  fb[16];
      logic [31:0] fpos, hdr_start, skip_left, img_count, entry_no;
      logic [15:0] tags_left;
      logic        big_end;
      loc_item_type pending_locs[$];
      int          fail_count;

      function new();
         clear();
         fail_count = 0;
      endfunction

      function void clear();
         phase = PH_SOI; fill = 0; fpos = 0; hdr_start = 0; skip_left = 0;
         img_count = 0; entry_no = 0; tags_left = 0; big_end = 0;
         foreach (fb[i]) fb[i] = 8'h00;
      endfunction

      function logic [15:0] get16(int o, logic be);
         return be ? {fb[o], fb[o+1]} : {fb[o+1], fb[o]};
      endfunction

      function logic [31:0] get32(int o, logic be);
         return be ? {get16(o, be), get16(o+2, be)} : {get16(o+2, be), get16(o, be)};
      endfunction

      function void push_error(logic [4:0] code);
         loc_item_type r;
         phase = PH_HALT;
         r = '0; r.is_error = 1; r.error_code = code; r.last = 1;
         pending_locs.push_back(r);
      endfunction

      function void tags_done();
         if (img_count == 0) push_error(ERR_NO_IMAGES);
         else phase = PH_NEXTIFD;
      endfunction

      function void parse_tag();
         logic [15:0] tag, typ;
         logic [63:0] cnt;
         tag = get16(0, big_end);
         typ = get16(2, big_end);
         cnt = get32(4, big_end);
         case (tag)
            TAG_VERSION: begin
               if (typ != TYPE_UNDEF) begin push_error(ERR_B000_TYPE); return; end
               if (cnt != 4) begin push_error(ERR_B000_CNT); return; end
               if (fb[8] != "0" || fb[9] != "1" || fb[10] != "0" || fb[11] != "0") begin
                  push_error(ERR_B000_VER); return;
               end
            end
            TAG_NUM_IMG: begin
               if (typ != TYPE_LONG) begin push_error(ERR_B001_TYPE); return; end
               if (cnt != 1) begin push_error(ERR_B001_CNT); return; end
               img_count = get32(8, big_end);
            end
            TAG_ENTRY: begin
               if (typ != TYPE_UNDEF) begin push_error(ERR_B002_TYPE); return; end
               if (cnt != 64'(img_count) * 16) begin push_error(ERR_B002_CNT); return; end
            end
            TAG_UID: begin
               if (typ != TYPE_UNDEF) begin push_error(ERR_B003_TYPE); return; end
               if (cnt != 64'(img_count) * 33) begin push_error(ERR_B003_CNT); return; end
            end
            TAG_FRAMES: begin
               if (typ != TYPE_LONG) begin push_error(ERR_B004_TYPE); return; end
               if (cnt != 1) begin push_error(ERR_B004_CNT); return; end
            end
            default: begin
               push_error(ERR_BAD_TAG); return;
            end
         endcase
         tags_left = tags_left - 1;
         if (tags_left == 0) tags_done();
      endfunction

      function void finish_field(logic [31:0] pos);
         logic [31:0] v;
         loc_item_type r;
         case (phase)
            PH_SOI: begin
               if (fb[0] != MK_PREFIX || fb[1] != MK_SOI) push_error(ERR_NO_SOI);
               else phase = PH_MARKER;
            end
            PH_MARKER: begin
               if (fb[0] != MK_PREFIX) push_error(ERR_MARKER);
               else if (fb[1] == MK_APP2) phase = PH_MPF;
               else begin
                  v = {16'h0, fb[2], fb[3]};
                  if (v < 2) push_error(ERR_SHORT_SEG);
                  else begin
                     skip_left = v - 2;
                     phase = (skip_left != 0) ? PH_SKIPSEG : PH_MARKER;
                  end
               end
            end
            PH_MPF: begin
               if (fb[0] != "M" || fb[1] != "P" || fb[2] != "F" || fb[3] != 8'h00)
                  push_error(ERR_NOT_MPF);
               else begin
                  hdr_start = pos + 1;
                  phase = PH_MPHDR;
               end
            end
            PH_MPHDR: begin
               if (fb[0] == 8'h49 && fb[1] == 8'h49 && fb[2] == 8'h2A && fb[3] == 8'h00)
                  big_end = 0;
               else if (fb[0] == 8'h4D && fb[1] == 8'h4D && fb[2] == 8'h00 && fb[3] == 8'h2A)
                  big_end = 1;
               else begin
                  push_error(ERR_ENDIAN); return;
               end
               v = get32(4, big_end);
               if (v < 8) push_error(ERR_IFD_OFS);
               else begin
                  skip_left = v - 8;
                  phase = (skip_left != 0) ? PH_SKIPIFD : PH_COUNT;
               end
            end
            PH_COUNT: begin
               tags_left = get16(0, big_end);
               if (tags_left == 0) tags_done();
               else phase = PH_TAG;
            end
            PH_TAG: parse_tag();
            PH_NEXTIFD: begin
               entry_no = 0;
               phase = PH_ENTRY;
            end
            PH_ENTRY: begin
               r = '0;
               r.image_index = entry_no;
               r.image_location = {1'b0, hdr_start} + {1'b0, get32(8, big_end)};
               r.last = (entry_no == img_count - 1);
               pending_locs.push_back(r);
               entry_no = entry_no + 1;
               if (r.last) phase = PH_DONE;
            end
            default: ;
         endcase
      endfunction

      // Notes one accepted input item and predicts what it causes.
      function void note_byte(logic [7:0] b, logic fs);
         logic [31:0] pos;
         int unsigned flen;
         if (fs) clear();
         pos = fpos;
         fpos = fpos + 1;
         if (phase == PH_HALT || phase == PH_DONE) return;
         if (phase == PH_SKIPSEG || phase == PH_SKIPIFD) begin
            skip_left = skip_left - 1;
            if (skip_left == 0) phase = (phase == PH_SKIPSEG) ? PH_MARKER : PH_COUNT;
            return;
         end
         case (phase)
            PH_SOI, PH_COUNT: flen = 2;
            PH_MPHDR: flen = 8;
            PH_TAG: flen = 12;
            PH_ENTRY: flen = 16;
            default: flen = 4;
         endcase
         fb[fill] = b;
         if (fill + 1 < flen) begin
            fill = fill + 1;
            return;
         end
         fill = 0;
         finish_field(pos);
      endfunction

      // Checks one accepted result item against the oldest prediction.
      function void check_loc(loc_item_type got);
         loc_item_type exp_r;
         if (pending_locs.size() == 0) begin
            $error("unexpected result item");
            fail_count++;
            return;
         end
         exp_r = pending_locs.pop_front();
         if (got.is_error !== exp_r.is_error) begin
            $error("is_error: expected %0d, got %0d", exp_r.is_error, got.is_error);
            fail_count++;
         end
         if (got.error_code !== exp_r.error_code) begin
            $error("error_code: expected %0d, got %0d", exp_r.error_code, got.error_code);
            fail_count++;
         end
         if (got.image_index !== exp_r.image_index) begin
            $error("image_index: expected %0d, got %0d", exp_r.image_index, got.image_index);
            fail_count++;
         end
         if (got.image_location !== exp_r.image_location) begin
            $error("image_location: expected %0h, got %0h",
                   exp_r.image_location, got.image_location);
            fail_count++;
         end
         if (got.last !== exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, got.last);
            fail_count++;
         end
      endfunction
   endclass

   localparam int IDLE_LIMIT = 20000;
   localparam int ITEM_TARGET = 500;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 0;
   logic        req_file_start = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic        rsp_is_error;
   logic [4:0]  rsp_error_code;
   logic [31:0] rsp_image_index;
   logic [32:0] rsp_image_location;
   logic        rsp_last;

   mpo_index_parser_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_data_byte(req_data_byte), .req_file_start(req_file_start),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_is_error(rsp_is_error), .rsp_error_code(rsp_error_code),
      .rsp_image_index(rsp_image_index), .rsp_image_location(rsp_image_location),
      .rsp_last(rsp_last)
   );

   mpo_scoreboard board = new();

   // The byte stream of the current file is assembled here before it is sent.
   logic [7:0] file_bytes[$];
   int         idle_cycles = 0;
   int         items_sent = 0;
   bit         stall_free = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   // Gap length: most gaps are short, a few are long, none in quiet stretches.
   function automatic int gap_len();
      int r;
      if (stall_free) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Results are sampled at the edge where they are accepted; the ready line
   // then gets its next value with a single nonblocking assignment.
   initial begin
      int gap;
      gap = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            board.check_loc({rsp_is_error, rsp_error_code, rsp_image_index,
                             rsp_image_location, rsp_last});
         if (gap > 0) begin
            gap--;
            rsp_ready <= 0;
         end else begin
            gap = gap_len();
            rsp_ready <= (gap == 0);
         end
      end
   end

   // The watchdog ends the run when nothing moves for too long.
   initial begin
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Sends one byte; valid stays up across back-to-back items.
   task automatic send_byte(logic [7:0] b, logic fs);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data_byte <= b;
      req_file_start <= fs;
      do @(posedge clock); while (!req_ready);
      board.note_byte(b, fs);
      items_sent++;
   endtask

   // A halted parser ignores the rest of a broken file, so it is cut short there.
   task automatic send_file();
      foreach (file_bytes[i]) begin
         send_byte(file_bytes[i], i == 0);
         if (board.phase == PH_HALT) break;
      end
      file_bytes.delete();
   endtask

   function automatic void put16(logic [15:0] v, logic be);
      if (be) begin file_bytes.push_back(v[15:8]); file_bytes.push_back(v[7:0]); end
      else begin file_bytes.push_back(v[7:0]); file_bytes.push_back(v[15:8]); end
   endfunction

   function automatic void put32(logic [31:0] v, logic be);
      if (be) begin put16(v[31:16], be); put16(v[15:0], be); end
      else begin put16(v[15:0], be); put16(v[31:16], be); end
   endfunction

   // Builds a well-formed MPO prefix and index. A nonzero "breakage" kind
   // corrupts one chosen spot so that each error path is reached.
   function automatic void build_file(int nimg, logic be, int nseg, int ifd_gap, int brk);
      logic [31:0] ofs;
      logic [15:0] ntag;
      file_bytes.push_back(MK_PREFIX);
      file_bytes.push_back(brk == 1 ? 8'hD9 : MK_SOI);
      for (int s = 0; s < nseg; s++) begin
         logic [15:0] len;
         len = 16'($urandom_range(2, 6));
         if (brk == 3 && s == 0) len = 16'($urandom_range(0, 1));
         file_bytes.push_back(brk == 2 && s == 0 ? 8'h00 : MK_PREFIX);
         file_bytes.push_back(8'hE0 + 8'($urandom_range(0, 1)));
         file_bytes.push_back(len[15:8]);
         file_bytes.push_back(len[7:0]);
         for (int k = 2; k < len; k++) file_bytes.push_back(8'($urandom));
      end
      file_bytes.push_back(MK_PREFIX);
      file_bytes.push_back(MK_APP2);
      file_bytes.push_back("M");
      file_bytes.push_back("P");
      file_bytes.push_back(brk == 4 ? "X" : "F");
      file_bytes.push_back(8'h00);
      if (brk == 5) begin
         file_bytes.push_back(8'h49); file_bytes.push_back(8'h4D);
         file_bytes.push_back(8'h2A); file_bytes.push_back(8'h00);
      end else if (be) begin
         file_bytes.push_back(8'h4D); file_bytes.push_back(8'h4D);
         file_bytes.push_back(8'h00); file_bytes.push_back(8'h2A);
      end else begin
         file_bytes.push_back(8'h49); file_bytes.push_back(8'h49);
         file_bytes.push_back(8'h2A); file_bytes.push_back(8'h00);
      end
      put32(brk == 6 ? 32'($urandom_range(0, 7)) : 32'(8 + ifd_gap), be);
      for (int k = 0; k < ifd_gap; k++) file_bytes.push_back(8'($urandom));
      if (brk == 19) begin
         put16(16'd0, be);
         return;
      end
      ntag = 4;
      put16(ntag, be);
      // Version tag.
      put16(brk == 18 ? 16'hB00F : TAG_VERSION, be);
      put16(brk == 7 ? TYPE_LONG : TYPE_UNDEF, be);
      put32(brk == 8 ? 32'd5 : 32'd4, be);
      file_bytes.push_back("0"); file_bytes.push_back(brk == 9 ? "2" : "1");
      file_bytes.push_back("0"); file_bytes.push_back("0");
      // Image count tag.
      put16(TAG_NUM_IMG, be);
      put16(brk == 10 ? TYPE_UNDEF : TYPE_LONG, be);
      put32(brk == 11 ? 32'd2 : 32'd1, be);
      put32(32'(nimg), be);
      // Entry table and unique-ID tags (their payload words are offsets, ignored).
      put16(TAG_ENTRY, be);
      put16(brk == 12 ? TYPE_LONG : TYPE_UNDEF, be);
      put32(32'(nimg * 16 + (brk == 13)), be);
      put32($urandom, be);
      if (brk == 16 || brk == 17) begin
         put16(TAG_FRAMES, be);
         put16(brk == 16 ? TYPE_UNDEF : TYPE_LONG, be);
         put32(brk == 17 ? 32'd0 : 32'd1, be);
      end else begin
         put16(TAG_UID, be);
         put16(brk == 14 ? TYPE_LONG : TYPE_UNDEF, be);
         put32(32'(nimg * 33 + (brk == 15)), be);
      end
      put32($urandom, be);
      put32($urandom, be);
      for (int e = 0; e < nimg; e++) begin
         put32($urandom, be);
         put32($urandom, be);
         put32(e == 0 ? 32'h0 : (e == 1 ? 32'hFFFF_FFFF : $urandom), be);
         put32($urandom, be);
      end
      // Trailing bytes that the parser must ignore.
      for (int k = 0; k < 3; k++) file_bytes.push_back(8'($urandom));
   endfunction

   task automatic wait_drained();
      while (board.pending_locs.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: a clean file in both byte orders.
      stall_free = 1;
      build_file(2, 0, 1, 0, 0); send_file();
      stall_free = 0;
      build_file(3, 1, 0, 4, 0); send_file();
      // Random bytes with occasional file starts exercise the no-SOI path and all bits.
      for (int k = 0; k < 20; k++) send_byte(8'($urandom), $urandom_range(0, 7) == 0);

      // Random part: well-formed files, broken files and noise until the item budget.
      while (items_sent < ITEM_TARGET) begin
         int r;
         r = $urandom_range(0, 9);
         stall_free = ($urandom_range(0, 5) == 0);
         if (r < 5) build_file($urandom_range(1, 3), $urandom_range(0, 1),
                               $urandom_range(0, 2), $urandom_range(0, 4), 0);
         else if (r < 9) build_file($urandom_range(1, 3), $urandom_range(0, 1),
                                    $urandom_range(0, 2), $urandom_range(0, 3),
                                    $urandom_range(1, 19));
         else for (int k = 0; k < 10; k++) file_bytes.push_back(8'($urandom));
         send_file();
      end
      req_valid <= 0;
      stall_free = 0;
      wait_drained();
      repeat (20) @(posedge clock);
      if (board.fail_count == 0 && board.pending_locs.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire
